>>> src/mbcb_pkg.sv
// Shared types and constants for the clipped 1bpp blit block.
// No dependencies; imported by every module of the block except mbcb_fifo.
`timescale 1ns / 1ps
`default_nettype none

package mbcb_pkg;

  localparam int unsigned IDX_W      = 17;  // destination byte index width
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd6;

  // One classified source byte: up to two destination byte writes.
  typedef struct packed {
    logic [IDX_W-1:0]  row_off;  // dest row times stride, modulo 2^17
    logic [IDX_W-1:0]  base;     // column byte of the first slot, two's complement
    logic [BYTE_W-1:0] bits0;
    logic [BYTE_W-1:0] mask0;
    logic [BYTE_W-1:0] bits1;
    logic [BYTE_W-1:0] mask1;
  } blit_rec_t;

  // One destination write as seen on the result ports.
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] bits;
    logic [BYTE_W-1:0] mask;
    logic              last;
  } blit_wr_t;

endpackage

`default_nettype wire

>>> src/mbcb_fifo.sv
// Short flop-based queue between the classifier and the write sequencer.
// Generic width and depth; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mbcb_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/mbcb_front.sv
// Front end: tracks source row/byte position, clips eight pixels, forms
// the two-slot write record. Depends on mbcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbcb_front #(
  parameter int unsigned DIM_W    = 11,
  parameter int unsigned ROW_W    = 10,
  parameter int unsigned COL_W    = 8,
  parameter int unsigned STRIDE_W = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // source byte channel
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [mbcb_pkg::BYTE_W-1:0] src_byte_i,
  input  wire logic                        start_image_i,
  // configuration, already saturated
  input  wire logic signed [10:0]          dest_x_i,
  input  wire logic signed [10:0]          dest_y_i,
  input  wire logic [DIM_W-1:0]            iw_i,
  input  wire logic [DIM_W-1:0]            ih_i,
  input  wire logic [DIM_W-1:0]            cw_i,
  input  wire logic [DIM_W-1:0]            ch_i,
  input  wire logic [STRIDE_W-1:0]         stride_i,
  input  wire logic [COL_W-1:0]            sstride_i,
  // record toward the queue
  output mbcb_pkg::blit_rec_t              rec_o,
  output logic                             rec_vld_o,
  input  wire logic                        q_full_i
);
  import mbcb_pkg::*;

  localparam int unsigned AW = DIM_W + 2;
  localparam int unsigned PW = DIM_W + 1 + STRIDE_W;

  logic [ROW_W-1:0]        row_q, row_d, cur_row;
  logic [COL_W-1:0]        col_q, col_d, cur_col;
  logic [COL_W+2:0]        cx;
  logic signed [AW-1:0]    py, px0;
  logic signed [AW-1:0]    px [8];
  logic [AW-1:0]           sx [8];
  logic                    row_ok, py_ok;
  logic [7:0]              vis;
  logic [15:0]             mask16, bits16;
  logic [PW-1:0]           prod;
  logic [COL_W:0]          col_inc;
  logic [ROW_W:0]          row_inc;
  logic [DIM_W-1:0]        hwrap;
  logic                    accept, has_write;
  blit_rec_t               rec_d, rec_q;
  logic                    rec_vld_q;

  assign full      = rec_vld_q && q_full_i;
  assign accept    = push && !full;
  assign rec_o     = rec_q;
  assign rec_vld_o = rec_vld_q;

  assign cur_row = start_image_i ? '0 : row_q;
  assign cur_col = start_image_i ? '0 : col_q;
  assign cx      = {cur_col, 3'b000};

  // Pixel clipping: row test once, column tests per pixel
  always_comb begin
    py     = $signed(AW'(dest_y_i)) + $signed(AW'(cur_row));
    px0    = $signed(AW'(dest_x_i)) + $signed(AW'(cx));
    row_ok = DIM_W'(cur_row) < ih_i;
    py_ok  = !py[AW-1] && (py[AW-2:0] < (AW-1)'(ch_i));
    for (int k = 0; k < 8; k++) begin
      sx[k] = AW'(cx) + AW'(k);
      px[k] = px0 + $signed(AW'(k));
      vis[7-k] = row_ok && py_ok && (sx[k] < AW'(iw_i)) && !px[k][AW-1] &&
                 (px[k][AW-2:0] < (AW-1)'(cw_i));
    end
    // slide the eight pixels into a two-byte window by the bit phase
    mask16 = {vis, 8'h00} >> px0[2:0];
    bits16 = {(~src_byte_i) & vis, 8'h00} >> px0[2:0];
    prod   = PW'(py[AW-2:0]) * PW'(stride_i);

    rec_d.row_off = IDX_W'(prod);
    rec_d.base    = IDX_W'(px0 >>> 3);
    rec_d.mask0   = mask16[15:8];
    rec_d.bits0   = bits16[15:8];
    rec_d.mask1   = mask16[7:0];
    rec_d.bits1   = bits16[7:0];
    has_write     = (vis != 8'h00);
  end

  // Position advance
  always_comb begin
    col_inc = (COL_W+1)'(cur_col) + 1'b1;
    row_inc = (ROW_W+1)'(cur_row) + 1'b1;
    hwrap   = (ih_i == '0) ? DIM_W'(1) : ih_i;
    row_d   = cur_row;
    col_d   = col_inc[COL_W-1:0];
    if (col_inc >= (COL_W+1)'(sstride_i)) begin
      col_d = '0;
      if ((DIM_W+1)'(row_inc) >= (DIM_W+1)'(hwrap)) begin
        row_d = '0;
      end else begin
        row_d = row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      rec_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q     <= row_d;
        col_q     <= col_d;
        rec_vld_q <= has_write;
      end else if (!q_full_i) begin
        rec_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q <= rec_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mbcb_back.sv
// Back end: walks each queued record slot by slot into the result register.
// Depends on mbcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbcb_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mbcb_pkg::blit_rec_t rec_i,
  input  wire logic                rec_vld_i,
  output logic                     rec_pop_o,
  output mbcb_pkg::blit_wr_t       wr_o,
  output logic                     empty,
  input  wire logic                pop
);
  import mbcb_pkg::*;

  logic     slot_q;
  logic     out_vld_q;
  blit_wr_t out_q, out_d;
  logic     out_free, sel1, load;

  assign out_free = !out_vld_q || pop;
  assign load     = rec_vld_i && out_free;
  assign sel1     = slot_q || (rec_i.mask0 == '0);

  always_comb begin
    out_d.index = rec_i.row_off + rec_i.base + IDX_W'(sel1);
    out_d.bits  = sel1 ? rec_i.bits1 : rec_i.bits0;
    out_d.mask  = sel1 ? rec_i.mask1 : rec_i.mask0;
    out_d.last  = sel1 || (rec_i.mask1 == '0);
  end

  assign rec_pop_o = load && out_d.last;
  assign wr_o      = out_q;
  assign empty     = !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        slot_q    <= !out_d.last;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  // second slot pending only while its record is still at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q |-> (rec_vld_i && rec_i.mask1 != '0))
    else $error("second slot pending without a record");

  // the front never queues a record without a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_vld_i |-> (rec_i.mask0 != '0 || rec_i.mask1 != '0))
    else $error("empty record in queue");

  // a shown write has a mask and no data outside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.mask != '0 && (out_q.bits & ~out_q.mask) == '0))
    else $error("bad write mask or data");

  // a first-slot write that is not last is followed by the second slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !out_d.last) |=> (slot_q && out_vld_q))
    else $error("first slot not followed by second");

endmodule

`default_nettype wire

>>> src/mono_bitmap_clipped_blit.sv
// Top level of the clipped 1bpp blit: configuration registers, classifier,
// record queue and write sequencer. Depends on mbcb_pkg, mbcb_front,
// mbcb_fifo and mbcb_back.
`timescale 1ns / 1ps
`default_nettype none

// Opaque clipped blit of a 1-bit-per-pixel image into a 1-bit canvas. Push
// source bytes in raster order (MSB is the leftmost pixel, rows padded to
// whole bytes); set start_image_i on the first byte of an image, or just
// keep streaming, since the position wraps after the last row. Each byte
// yields zero, one or two masked write transactions on the result side:
// dst_index_o is row * stride + column byte (modulo 2^17, add your own base),
// dst_bits_o holds the inverted pixels (a set source bit clears the canvas
// bit), and only bits under bit_mask_o are to be replaced. last_write_o
// flags the final write of its source byte. Bytes fully clipped or fully
// padding produce nothing. Rate: a byte is accepted every cycle while the
// record queue has room; the result side moves one write per cycle while
// pop is held, so a byte that hits one canvas byte takes one write and a
// byte that straddles two takes two. A write reaches the result ports
// through the classifier register, the record queue and the result register,
// in that order. Size registers saturate at MAX_DIM and row_stride at
// MAX_STRIDE_BYTES. Configuration is written through cfg_valid_i/cfg_ready_o
// (always ready) and must only change while the block is idle; indexes
// beyond the register list are ignored.

module mono_bitmap_clipped_blit #(
  parameter int unsigned MAX_DIM          = 1024,
  parameter int unsigned MAX_STRIDE_BYTES = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write transactions
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mbcb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mbcb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // source byte queue side
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [mbcb_pkg::BYTE_W-1:0]     src_byte_i,
  input  wire logic                            start_image_i,
  // destination write queue side
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [mbcb_pkg::IDX_W-1:0]           dst_index_o,
  output logic [mbcb_pkg::BYTE_W-1:0]          dst_bits_o,
  output logic [mbcb_pkg::BYTE_W-1:0]          bit_mask_o,
  output logic                                 last_write_o
);
  import mbcb_pkg::*;

  // widths that follow from the size limits
  localparam int unsigned DIM_W    = ($clog2(MAX_DIM + 1) > 11) ? $clog2(MAX_DIM + 1) : 11;
  localparam int unsigned ROW_W    = $clog2(MAX_DIM);
  localparam int unsigned COL_W    = $clog2((MAX_DIM + 7) / 8 + 1);
  localparam int unsigned STRIDE_W = ($clog2(MAX_STRIDE_BYTES + 1) > 8) ?
                                     $clog2(MAX_STRIDE_BYTES + 1) : 8;
  localparam int unsigned REC_DEPTH = 2;

  // saturate a size register to MAX_DIM
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] w;
    w = DIM_W'(v);
    if (w > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return w;
  endfunction

  function automatic logic [STRIDE_W-1:0] sat_stride(input logic [7:0] v);
    logic [STRIDE_W-1:0] w;
    w = STRIDE_W'(v);
    if (w > STRIDE_W'(MAX_STRIDE_BYTES)) begin
      return STRIDE_W'(MAX_STRIDE_BYTES);
    end
    return w;
  endfunction

  // source bytes per row, never below one
  function automatic logic [COL_W-1:0] row_bytes(input logic [DIM_W-1:0] w);
    logic [DIM_W:0] t;
    t = ((DIM_W+1)'(w) + (DIM_W+1)'(7)) >> 3;
    if (t == '0) begin
      return COL_W'(1);
    end
    return COL_W'(t);
  endfunction

  // configuration registers; sizes are kept already saturated
  logic signed [10:0]  dest_x_q, dest_y_q;
  logic [DIM_W-1:0]    iw_q, ih_q, cw_q, ch_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [COL_W-1:0]    sstride_q;
  logic                cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q  <= 11'sd24;
      dest_y_q  <= -11'sd18;
      iw_q      <= sat_dim(11'd8);
      ih_q      <= sat_dim(11'd8);
      cw_q      <= sat_dim(11'd128);
      ch_q      <= sat_dim(11'd128);
      stride_q  <= sat_stride(8'd16);
      sstride_q <= row_bytes(sat_dim(11'd8));
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_DEST_X:        dest_x_q <= $signed(cfg_data_i);
        REG_DEST_Y:        dest_y_q <= $signed(cfg_data_i);
        REG_IMAGE_WIDTH: begin
          iw_q      <= sat_dim(cfg_data_i);
          sstride_q <= row_bytes(sat_dim(cfg_data_i));
        end
        REG_IMAGE_HEIGHT:  ih_q     <= sat_dim(cfg_data_i);
        REG_CANVAS_WIDTH:  cw_q     <= sat_dim(cfg_data_i);
        REG_CANVAS_HEIGHT: ch_q     <= sat_dim(cfg_data_i);
        REG_ROW_STRIDE:    stride_q <= sat_stride(cfg_data_i[7:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front -> queue -> back
  blit_rec_t front_rec, q_rec;
  logic      front_vld, q_full, q_empty, q_pop;
  blit_wr_t  wr;

  mbcb_front #(
    .DIM_W    (DIM_W),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W),
    .STRIDE_W (STRIDE_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .src_byte_i    (src_byte_i),
    .start_image_i (start_image_i),
    .dest_x_i      (dest_x_q),
    .dest_y_i      (dest_y_q),
    .iw_i          (iw_q),
    .ih_i          (ih_q),
    .cw_i          (cw_q),
    .ch_i          (ch_q),
    .stride_i      (stride_q),
    .sstride_i     (sstride_q),
    .rec_o         (front_rec),
    .rec_vld_o     (front_vld),
    .q_full_i      (q_full)
  );

  mbcb_fifo #(
    .DEPTH (REC_DEPTH),
    .WIDTH ($bits(blit_rec_t))
  ) u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rec),
    .empty_o (q_empty)
  );

  mbcb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_i     (q_rec),
    .rec_vld_i (!q_empty),
    .rec_pop_o (q_pop),
    .wr_o      (wr),
    .empty     (empty),
    .pop       (pop)
  );

  assign dst_index_o  = wr.index;
  assign dst_bits_o   = wr.bits;
  assign bit_mask_o   = wr.mask;
  assign last_write_o = wr.last;

endmodule

`default_nettype wire
